### sv/psa_pkg.sv
package psa_pkg;
   localparam int SLOTS = 4;
   localparam int SLOT_W = 2;
   localparam logic [15:0] PRIO_MIN = 16'h8000;
   localparam logic [15:0] PRIO_MAX = 16'h7fff;
   localparam logic [19:0] TICK_MAX = 20'hfffff;
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam logic CSR_SLICE = 1'b0;
   localparam logic CSR_AGING = 1'b1;
endpackage

### sv/priority_scheduler_with_aging_top.sv
// channel | ports  | tdata fields (low bit up)
// req     | req_*  | opcode, slot, arrival, burst, priority_req
// rsp     | rsp_*  | running_slot, switched, previous_slot, switch_time,
//         |        | finished, waiting_time, idle
// csr     | csr_*  | write enable, index, 8-bit data
// A load, start or other item passes from acceptance through an update state
// to the output register; a tick with a slot not yet done passes setup, a
// scan of one slot per cycle through a shared compare unit, update with
// aging, then result. Reset is synchronous; all slots start done.
// A result waits in the output register; the next item is accepted the cycle
// after it has been taken.
module priority_scheduler_with_aging_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // opcode, slot, arrival, burst, priority_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // running_slot, switched, previous_slot,
                                   // switch_time, finished, waiting_time, idle
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_AGE, S_OUT} state_type;
   localparam int SW = psa_pkg::SLOT_W;

   state_type state_ff;
   logic [55:0] item_ff;
   logic [15:0] arr_ff [psa_pkg::SLOTS];
   logic [15:0] rem_ff [psa_pkg::SLOTS];
   logic [15:0] org_ff [psa_pkg::SLOTS];
   logic signed [15:0] pri_ff [psa_pkg::SLOTS];
   logic [3:0] age_ff [psa_pkg::SLOTS];
   logic [psa_pkg::SLOTS-1:0] done_ff;
   logic [SW-1:0] cur_ff, last_ff, idx_ff, pick_ff;
   logic [7:0] slice_ff, tslice_ff;
   logic [3:0] aper_ff;
   logic signed [15:0] thr_ff, best_ff;
   logic found_ff, mode_ff;
   logic [19:0] tick_ff;
   logic rsp_v_ff;
   logic [47:0] rsp_ff;

   logic [1:0] op;
   assign op = item_ff[1:0];
   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_ff;

   // shared compare unit: one slot per scan cycle
   logic arrived, cand, better;
   assign arrived = {4'd0, tick_ff} >= {8'd0, arr_ff[idx_ff]};
   assign better = mode_ff ? (!found_ff || pri_ff[idx_ff] > best_ff)
                           : (pri_ff[idx_ff] > best_ff);
   assign cand = arrived && !done_ff[idx_ff] && better &&
                 (!mode_ff || idx_ff != cur_ff);

   // completion arithmetic
   logic signed [21:0] wt;
   logic [15:0] rem_dec;
   logic worked, fin;
   assign rem_dec = (rem_ff[cur_ff] != 16'd0) ? rem_ff[cur_ff] - 16'd1 : 16'd0;
   assign worked = !done_ff[cur_ff];
   assign fin = worked && rem_dec == 16'd0;
   assign wt = $signed({2'b00, tick_ff}) - $signed({6'd0, arr_ff[cur_ff]})
             - $signed({6'd0, org_ff[cur_ff]});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
         done_ff <= '1;
         cur_ff <= '0; last_ff <= '0;
         tslice_ff <= 8'd5; aper_ff <= 4'd3; slice_ff <= 8'd5;
         thr_ff <= psa_pkg::PRIO_MIN; tick_ff <= '0;
         for (int i = 0; i < psa_pkg::SLOTS; i++) age_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == psa_pkg::CSR_SLICE) tslice_ff <= csr_wdata;
            else aper_ff <= csr_wdata[3:0];
         end
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               item_ff <= req_tdata;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               rsp_ff <= {1'b0, 1'b1, 46'd0};
               if (op == psa_pkg::OP_LOAD) begin
                  arr_ff[item_ff[3:2]] <= item_ff[19:4];
                  org_ff[item_ff[3:2]] <= item_ff[35:20];
                  rem_ff[item_ff[3:2]] <= item_ff[35:20];
                  pri_ff[item_ff[3:2]] <= item_ff[51:36];
                  age_ff[item_ff[3:2]] <= '0;
                  done_ff[item_ff[3:2]] <= item_ff[35:20] == 16'd0;
                  state_ff <= S_OUT;
               end else if (op == psa_pkg::OP_START) begin
                  cur_ff <= '0; last_ff <= '0; slice_ff <= tslice_ff;
                  thr_ff <= pri_ff[0]; tick_ff <= '0;
                  for (int i = 0; i < psa_pkg::SLOTS; i++) age_ff[i] <= '0;
                  state_ff <= S_OUT;
               end else if (op == psa_pkg::OP_TICK && !(&done_ff)) begin
                  // set up the scan
                  mode_ff <= !(slice_ff != 8'd0 && !done_ff[cur_ff]);
                  if (!(slice_ff != 8'd0 && !done_ff[cur_ff])) begin
                     best_ff <= psa_pkg::PRIO_MIN;
                     pri_ff[cur_ff] <= (pri_ff[cur_ff] == psa_pkg::PRIO_MIN) ?
                        pri_ff[cur_ff] : pri_ff[cur_ff] - 16'sd1;
                  end else best_ff <= thr_ff;
                  found_ff <= 1'b0; pick_ff <= cur_ff; idx_ff <= '0;
                  state_ff <= S_SCAN;
               end else state_ff <= S_OUT;
            end
            S_SCAN: begin
               if (cand) begin
                  best_ff <= pri_ff[idx_ff]; found_ff <= 1'b1; pick_ff <= idx_ff;
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == SW'(psa_pkg::SLOTS-1)) state_ff <= S_AGE;
            end
            S_AGE: begin
               logic [7:0] sl;
               logic [19:0] tn;
               logic [47:0] rs;
               logic sw;
               sl = slice_ff;
               sw = last_ff != pick_ff;
               tn = (tick_ff != psa_pkg::TICK_MAX) ? tick_ff + 20'd1 : tick_ff;
               rs = '0;
               rs[1:0] = pick_ff;
               thr_ff <= best_ff;
               if (sw) begin
                  rs[2] = 1'b1; rs[4:3] = last_ff;
                  rs[24:5] = tick_ff; sl = tslice_ff; last_ff <= pick_ff;
               end
               rsp_ff <= rs;
               tick_ff <= tn;
               if (sl != 8'd0) sl = sl - 8'd1;
               for (int k = 0; k < psa_pkg::SLOTS; k++) begin
                  if (SW'(k) != pick_ff && tn > {4'd0, arr_ff[k]}) begin
                     if (age_ff[k] + 4'd1 >= ((aper_ff == 4'd0) ? 4'd1 : aper_ff)
                         || age_ff[k] == 4'hf) begin
                        age_ff[k] <= '0;
                        if (pri_ff[k] != psa_pkg::PRIO_MAX) pri_ff[k] <= pri_ff[k] + 16'sd1;
                     end else age_ff[k] <= age_ff[k] + 4'd1;
                  end
               end
               cur_ff <= pick_ff;
               slice_ff <= sl;
               state_ff <= S_OUT;
               mode_ff <= 1'b0;
               idx_ff <= pick_ff;
            end
            S_OUT: begin
               // finish work on the running slot, then show the result
               if (op == psa_pkg::OP_TICK && rsp_ff[46] == 1'b0) begin
                  if (worked) rem_ff[cur_ff] <= rem_dec;
                  if (fin) begin
                     rsp_ff[45:25] <= {(wt[21] ? 20'd0 :
                        (wt[20] ? psa_pkg::TICK_MAX : wt[19:0])), 1'b1};
                     done_ff[cur_ff] <= 1'b1;
                     slice_ff <= tslice_ff; last_ff <= cur_ff;
                  end
               end
               rsp_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### sv/psa_checker.sv
module psa_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [47:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready with result pending");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[46] |-> rsp_tdata[45:0] == 46'd0)
      else $error("idle result has fields");
endmodule

bind priority_scheduler_with_aging_top psa_checker u_chk (.*);
